/* rtl/core/gnos_pkg.sv */
// Shared types, constants and tables for the gradient noise octave sum unit.
package gnos_pkg;

	localparam int ANGLE_BITS     = 8;
	localparam int MAX_OCTAVES    = 8;
	localparam int COORD_INT_BITS = 16;
	localparam int FRAC_BITS      = 32 - COORD_INT_BITS;
	localparam int SW             = 32 + FRAC_BITS;
	localparam int CNT_W          = 4;
	localparam int OCT_W          = $clog2(MAX_OCTAVES + 1);
	localparam int NOISE_W        = 19;
	localparam int ACC_W          = NOISE_W + MAX_OCTAVES + 1;
	localparam int ADDR_W         = 3;

	localparam logic [31:0] HASH_K1 = 32'd3284157443;
	localparam logic [31:0] HASH_K2 = 32'd1911520717;
	localparam logic [31:0] HASH_K3 = 32'd2048419325;

	localparam logic [ADDR_W-1:0] REG_OCTAVE_COUNT = 3'd0;
	localparam logic [CNT_W-1:0]  OCTAVE_RESET     = 4'd6;

	typedef struct packed {
		logic                    valid;
		logic [SW-1:0]           sx;
		logic [SW-1:0]           sy;
		logic signed [ACC_W-1:0] acc;
		logic [CNT_W-1:0]        n;
		logic [OCT_W-1:0]        oct;
	} pass_t;

	function automatic logic [31:0] recip_lut(input logic [CNT_W-1:0] n);
		logic [31:0] r;
		case (n)
			4'd1:    r = 32'd1073741824;
			4'd2:    r = 32'd357913941;
			4'd3:    r = 32'd153391689;
			4'd4:    r = 32'd71582788;
			4'd5:    r = 32'd34636833;
			4'd6:    r = 32'd17043521;
			4'd7:    r = 32'd8454660;
			4'd8:    r = 32'd4210752;
			4'd9:    r = 32'd2101256;
			4'd10:   r = 32'd1049601;
			4'd11:   r = 32'd524544;
			4'd12:   r = 32'd262208;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] rot16(input logic [31:0] v);
		return {v[15:0], v[31:16]};
	endfunction

endpackage

/* rtl/core/gnos_sine.sv */
// Pipelined polynomial sine of a 16-bit phase, Q1.15 result after four stages.
module gnos_sine (
	input  logic               clk,
	input  logic               en,
	input  logic [15:0]        phase,
	output logic signed [15:0] grad
);
	import gnos_pkg::*;

	localparam logic [31:0] POLY_A = 32'd51472;
	localparam logic [31:0] POLY_B = 32'd21024;
	localparam logic [31:0] POLY_C = 32'd2320;

	logic [15:0] p;
	logic        neg;
	logic [15:0] mag;
	logic [31:0] sq;
	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] yv;

	logic [16:0] x2_s4;
	logic [15:0] mag_s4, mag_s5, mag_s6;
	logic        neg_s4, neg_s5, neg_s6;
	logic [16:0] x2_s5;
	logic [15:0] t_s5;
	logic [15:0] t3_s6;
	logic signed [15:0] y_s7;

	always_comb begin
		p = phase;
		if (p >= 16'd16384 && p < 16'd49152) begin
			p = 16'd32768 - p;
		end
		neg = p[15];
		mag = neg ? 16'(17'h10000 - {1'b0, p}) : p;
		sq  = {16'd0, mag} * {16'd0, mag};
		t1  = POLY_C * {15'd0, x2_s4};
		t2  = {16'd0, t_s5} * {15'd0, x2_s5};
		yv  = {16'd0, mag_s6} * {16'd0, t3_s6};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x2_s4  <= sq[30:14];
			mag_s4 <= mag;
			neg_s4 <= neg;
			x2_s5  <= x2_s4;
			t_s5   <= 16'(POLY_B - (t1 >> 14));
			mag_s5 <= mag_s4;
			neg_s5 <= neg_s4;
			t3_s6  <= 16'(POLY_A - (t2 >> 14));
			mag_s6 <= mag_s5;
			neg_s6 <= neg_s5;
			if ((yv >> 14) > 32'd32767) begin
				y_s7 <= neg_s6 ? -16'sd32767 : 16'sd32767;
			end else begin
				y_s7 <= neg_s6 ? -$signed(yv[29:14]) : $signed(yv[29:14]);
			end
		end
	end

	assign grad = y_s7;

endmodule

/* rtl/core/gnos_cell.sv */
// One octave cell: corner hash, gradients, dots, smoothstep blend, accumulate.
module gnos_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  gnos_pkg::pass_t pin,
	output gnos_pkg::pass_t pout
);
	import gnos_pkg::*;

	localparam int LAT = 12;

	typedef struct packed {
		pass_t       p;
		logic [15:0] fx;
		logic [15:0] fy;
		logic [16:0] wx;
		logic [16:0] wy;
	} side_t;

	logic [31:0] x0, y0;
	logic [FRAC_BITS+15:0] fxw, fyw;
	logic [15:0] fx, fy;
	logic [31:0] ix [4];
	logic [31:0] iy [4];
	logic [31:0] fxx, fyy;
	logic [33:0] wxp, wyp;

	logic [LAT:1] vld_s;
	side_t        side_s [1:LAT];

	logic [31:0] a_s1 [4];
	logic [31:0] iy_s1 [4];
	logic [31:0] a_s2 [4];
	logic [31:0] b_s2 [4];
	logic [31:0] h_s3 [4];
	logic [15:0] f2x_s1, f2y_s1;

	logic [15:0]        ph_sin [4];
	logic [15:0]        ph_cos [4];
	logic signed [15:0] gx [4];
	logic signed [15:0] gy [4];
	logic signed [16:0] dx [4];
	logic signed [16:0] dy [4];

	logic signed [32:0]        px_s8 [4];
	logic signed [32:0]        py_s8 [4];
	logic signed [33:0]        dsum [4];
	logic signed [NOISE_W-1:0] dot_s9 [4];

	logic signed [NOISE_W:0]   dif_t, dif_b, dif_v;
	logic signed [37:0]        pt_s10, pb_s10;
	logic signed [NOISE_W-1:0] d0_s10, d2_s10;
	logic signed [NOISE_W-1:0] top_s11, bot_s11;
	logic signed [37:0]        pv_s12;
	logic signed [NOISE_W-1:0] top_s12;
	logic signed [NOISE_W-1:0] noise;
	logic                      active;
	pass_t                     out_s13;

	always_comb begin
		x0  = pin.sx[SW-1:FRAC_BITS];
		y0  = pin.sy[SW-1:FRAC_BITS];
		fxw = {pin.sx[FRAC_BITS-1:0], 16'd0};
		fyw = {pin.sy[FRAC_BITS-1:0], 16'd0};
		fx  = fxw[FRAC_BITS+15:FRAC_BITS];
		fy  = fyw[FRAC_BITS+15:FRAC_BITS];
		for (int c = 0; c < 4; c++) begin
			ix[c] = c[0] ? x0 + 32'd1 : x0;
			iy[c] = c[1] ? y0 + 32'd1 : y0;
		end
		fxx = {16'd0, fx} * {16'd0, fx};
		fyy = {16'd0, fy} * {16'd0, fy};
		wxp = {18'd0, f2x_s1} * (34'd196608 - {17'd0, side_s[1].fx, 1'b0});
		wyp = {18'd0, f2y_s1} * (34'd196608 - {17'd0, side_s[1].fy, 1'b0});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAT-1:1], pin.valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[1] <= '{p: pin, fx: fx, fy: fy, wx: 17'd0, wy: 17'd0};
			side_s[2] <= '{p: side_s[1].p, fx: side_s[1].fx, fy: side_s[1].fy,
				wx: wxp[32:16], wy: wyp[32:16]};
			for (int k = 3; k <= LAT; k++) begin
				side_s[k] <= side_s[k-1];
			end
			f2x_s1 <= fxx[31:16];
			f2y_s1 <= fyy[31:16];
			for (int c = 0; c < 4; c++) begin
				a_s1[c]  <= ix[c] * HASH_K1;
				iy_s1[c] <= iy[c];
				b_s2[c]  <= (iy_s1[c] ^ rot16(a_s1[c])) * HASH_K2;
				a_s2[c]  <= a_s1[c];
				h_s3[c]  <= (a_s2[c] ^ rot16(b_s2[c])) * HASH_K3;
			end
		end
	end

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			ph_sin[c] = {h_s3[c][31 -: ANGLE_BITS], {(16-ANGLE_BITS){1'b0}}};
			ph_cos[c] = ph_sin[c] + 16'd16384;
			dx[c] = c[0] ? $signed({1'b0, side_s[7].fx}) - 17'sd65536
				: $signed({1'b0, side_s[7].fx});
			dy[c] = c[1] ? $signed({1'b0, side_s[7].fy}) - 17'sd65536
				: $signed({1'b0, side_s[7].fy});
			dsum[c] = 34'(px_s8[c]) + 34'(py_s8[c]);
		end
	end

	for (genvar g = 0; g < 4; g++) begin : g_grad
		gnos_sine u_sin (.clk(clk), .en(en), .phase(ph_sin[g]), .grad(gx[g]));
		gnos_sine u_cos (.clk(clk), .en(en), .phase(ph_cos[g]), .grad(gy[g]));
	end

	always_comb begin
		dif_t  = (NOISE_W+1)'(dot_s9[1]) - (NOISE_W+1)'(dot_s9[0]);
		dif_b  = (NOISE_W+1)'(dot_s9[3]) - (NOISE_W+1)'(dot_s9[2]);
		dif_v  = (NOISE_W+1)'(bot_s11) - (NOISE_W+1)'(top_s11);
		noise  = top_s12 + pv_s12[NOISE_W+15:16];
		active = side_s[LAT].p.oct < OCT_W'(side_s[LAT].p.n);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 4; c++) begin
				px_s8[c]  <= dx[c] * gx[c];
				py_s8[c]  <= dy[c] * gy[c];
				dot_s9[c] <= dsum[c][NOISE_W+14:15];
			end
			pt_s10  <= dif_t * $signed({1'b0, side_s[9].wx});
			pb_s10  <= dif_b * $signed({1'b0, side_s[9].wx});
			d0_s10  <= dot_s9[0];
			d2_s10  <= dot_s9[2];
			top_s11 <= d0_s10 + pt_s10[NOISE_W+15:16];
			bot_s11 <= d2_s10 + pb_s10[NOISE_W+15:16];
			pv_s12  <= dif_v * $signed({1'b0, side_s[11].wy});
			top_s12 <= top_s11;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_s13 <= '0;
		end else if (en) begin
			out_s13.valid <= vld_s[LAT];
			out_s13.sx    <= side_s[LAT].p.sx << 1;
			out_s13.sy    <= side_s[LAT].p.sy << 1;
			out_s13.n     <= side_s[LAT].p.n;
			out_s13.oct   <= side_s[LAT].p.oct + OCT_W'(1);
			out_s13.acc   <= active
				? {side_s[LAT].p.acc[ACC_W-2:0], 1'b0} + ACC_W'(noise)
				: side_s[LAT].p.acc;
		end
	end

	assign pout = out_s13;

endmodule

/* rtl/core/gradient_noise_octave_sum_unit.sv */
// Top level: APB register, chain of octave cells, normalization and output skid.
// Path: one octave cell per octave over MAX_OCTAVES cells, then 2 normalize
// stages and the output register, at the default of eight cells.
// Throughput: one item per cycle while the output skid register is empty; each cell runs one octave.
// Reset: arst_n clears all valid bits and sets octave_count to 6.
module gradient_noise_octave_sum_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [31:0]                   x_coord,
	input  logic [31:0]                   y_coord,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [15:0]            noise_value,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [gnos_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import gnos_pkg::*;

	logic [CNT_W-1:0] oct_count_q;
	logic [CNT_W-1:0] n_clamp;
	logic             en;
	pass_t            link [MAX_OCTAVES+1];

	logic                       fin_v_s1, fin_v_s2;
	logic signed [ACC_W+31:0]   prod_s1;
	logic signed [ACC_W:0]      scaled;
	logic signed [15:0]         val_s2;
	logic                       out_v_q, skid_v_q;
	logic signed [15:0]         out_d_q, skid_d_q;

	assign pready = 1'b1;
	assign prdata = (paddr == REG_OCTAVE_COUNT) ? {28'd0, oct_count_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oct_count_q <= OCTAVE_RESET;
		end else if (psel && penable && pwrite && pready && paddr == REG_OCTAVE_COUNT) begin
			oct_count_q <= pwdata[CNT_W-1:0];
		end
	end

	always_comb begin
		if (oct_count_q == '0) begin
			n_clamp = CNT_W'(1);
		end else if (oct_count_q > CNT_W'(MAX_OCTAVES)) begin
			n_clamp = CNT_W'(MAX_OCTAVES);
		end else begin
			n_clamp = oct_count_q;
		end
	end

	assign en       = !skid_v_q;
	assign in_stall = !en;

	assign link[0] = '{valid: in_valid, sx: SW'(x_coord), sy: SW'(y_coord),
		acc: '0, n: n_clamp, oct: '0};

	for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_cell
		gnos_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.pin    (link[i]),
			.pout   (link[i+1])
		);
	end

	assign scaled = prod_s1[ACC_W+31:31];

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= link[MAX_OCTAVES].acc * $signed({1'b0, recip_lut(link[MAX_OCTAVES].n)});
			if (scaled > (ACC_W+1)'(32767)) begin
				val_s2 <= 16'sh7fff;
			end else if (scaled < -(ACC_W+1)'(32768)) begin
				val_s2 <= -16'sh8000;
			end else begin
				val_s2 <= scaled[15:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_v_s1 <= 1'b0;
			fin_v_s2 <= 1'b0;
		end else if (en) begin
			fin_v_s1 <= link[MAX_OCTAVES].valid;
			fin_v_s2 <= fin_v_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (!out_stall) begin
				skid_v_q <= 1'b0;
			end
		end else if (fin_v_s2) begin
			if (!out_v_q || !out_stall) begin
				out_v_q <= 1'b1;
			end else begin
				skid_v_q <= 1'b1;
			end
		end else if (!out_stall) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (!out_stall) begin
				out_d_q <= skid_d_q;
			end
		end else if (fin_v_s2) begin
			if (!out_v_q || !out_stall) begin
				out_d_q <= val_s2;
			end else begin
				skid_d_q <= val_s2;
			end
		end
	end

	assign out_valid   = out_v_q;
	assign noise_value = out_d_q;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q) else $error("skid item without output item");

	a_skid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_v_q && out_stall) |=> (skid_v_q && $stable(skid_d_q)))
		else $error("skid item lost while stalled");

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_v_q && out_stall) |=> $stable(fin_v_s2))
		else $error("pipeline advanced while skid full");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_v_q && !out_stall) |=> (out_v_q && !skid_v_q))
		else $error("skid item not moved to output");

endmodule

/* test/tb_top.sv */
// Testbench for the gradient noise octave sum unit: predictor, driver, monitor and checks.
`timescale 1ns / 1ps
module tb_top;
	import gnos_pkg::*;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
	} point_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [31:0]         x_coord;
	logic [31:0]         y_coord;
	logic                out_valid;
	logic                out_stall;
	logic signed [15:0]  noise_value;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;

	point_t              pending_points[$];
	logic signed [15:0]  expected_noise[$];
	logic [3:0]          model_octaves;
	int                  mismatch_count;
	int                  cycle_count;
	int                  burst_left;
	int                  gap_left;
	int                  stall_phase;
	bit                  driver_hold;
	bit                  in_fire;

	gradient_noise_octave_sum_unit DUT (.*);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic longint floor_sh(input longint v, input int s);
		return v >>> s;
	endfunction

	function automatic longint sine_val(input logic [31:0] phase);
		logic [31:0] p, mag, x2, t, y;
		bit neg;
		p = phase & 32'hFFFF;
		if (p >= 16384 && p < 49152)
			p = (32768 - p) & 32'hFFFF;
		neg = p >= 32768;
		mag = neg ? 65536 - p : p;
		x2 = (mag * mag) >> 14;
		t = (32'd2320 * x2) >> 14;
		t = 32'd21024 - t;
		t = (t * x2) >> 14;
		t = 32'd51472 - t;
		y = (mag * t) >> 14;
		if (y > 32767)
			y = 32767;
		return neg ? -longint'(y) : longint'(y);
	endfunction

	function automatic longint corner_grad(input logic [31:0] ix, input logic [31:0] iy,
			input longint dx, input longint dy);
		logic [31:0] a, b, ph;
		a = ix * HASH_K1;
		b = iy ^ {a[15:0], a[31:16]};
		b = b * HASH_K2;
		a = a ^ {b[15:0], b[31:16]};
		a = a * HASH_K3;
		ph = (a >> (32 - ANGLE_BITS)) << (16 - ANGLE_BITS);
		return floor_sh(dx * sine_val(ph) + dy * sine_val(ph + 32'd16384), 15);
	endfunction

	function automatic longint fade(input longint f);
		longint f2;
		f2 = (f * f) >>> 16;
		return (f2 * (196608 - 2 * f)) >>> 16;
	endfunction

	function automatic longint lerp_q16(input longint a0, input longint a1, input longint w);
		return a0 + floor_sh((a1 - a0) * w, 16);
	endfunction

	function automatic longint octave_sample(input logic [31:0] xc, input logic [31:0] yc,
			input int o);
		logic [63:0] sx, sy;
		logic [31:0] x0, y0;
		longint fx, fy, wx, top, bot;
		sx = {32'd0, xc} << o;
		sy = {32'd0, yc} << o;
		x0 = sx[FRAC_BITS +: 32];
		y0 = sy[FRAC_BITS +: 32];
		fx = longint'(((sx & ((64'd1 << FRAC_BITS) - 1)) << 16) >> FRAC_BITS);
		fy = longint'(((sy & ((64'd1 << FRAC_BITS) - 1)) << 16) >> FRAC_BITS);
		wx = fade(fx);
		top = lerp_q16(corner_grad(x0, y0, fx, fy), corner_grad(x0 + 1, y0, fx - 65536, fy), wx);
		bot = lerp_q16(corner_grad(x0, y0 + 1, fx, fy - 65536),
			corner_grad(x0 + 1, y0 + 1, fx - 65536, fy - 65536), wx);
		return lerp_q16(top, bot, fade(fy));
	endfunction

	function automatic logic signed [15:0] fbm_noise(input logic [31:0] xc, input logic [31:0] yc,
			input logic [3:0] cnt);
		int n;
		longint acc, den, r, v;
		n = cnt;
		acc = 0;
		if (n < 1)
			n = 1;
		if (n > MAX_OCTAVES)
			n = MAX_OCTAVES;
		for (int o = 0; o < n; o++)
			acc += octave_sample(xc, yc, o) * (longint'(1) << (n - 1 - o));
		den = (longint'(1) << n) - 1;
		r = ((longint'(1) << 30) + den / 2) / den;
		v = floor_sh(acc * r, 31);
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return v[15:0];
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		mismatch_count++;
	endtask

	task automatic write_octaves(input logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= REG_OCTAVE_COUNT;
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		model_octaves = val[3:0];
		if (prdata !== {28'd0, val[3:0]} || pready !== 1'b1)
			report_mismatch("prdata", prdata, val[3:0]);
	endtask

	task automatic drain();
		wait (pending_points.size() == 0 && expected_noise.size() == 0);
		repeat (130) @(negedge clk);
	endtask

	task automatic queue_point(input logic [31:0] xv, input logic [31:0] yv);
		pending_points.push_back('{x: xv, y: yv});
	endtask

	task automatic queue_random(input int count);
		logic [31:0] xv, yv;
		for (int i = 0; i < count; i++) begin
			xv = $urandom();
			yv = $urandom();
			case ($urandom_range(0, 3))
				0: begin
					xv = $urandom_range(0, 32'h000F_FFFF);
					yv = $urandom_range(0, 32'h000F_FFFF);
				end
				1: xv = 32'hFFFF_0000 | xv[15:0];
				default: ;
			endcase
			queue_point(xv, yv);
		end
	endtask

	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_fire) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (pending_points.size() != 0 && !driver_hold) begin
					in_valid <= 1'b1;
					x_coord <= pending_points[0].x;
					y_coord <= pending_points[0].y;
					expected_noise.push_back(fbm_noise(pending_points[0].x,
						pending_points[0].y, model_octaves));
					void'(pending_points.pop_front());
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 20);
						gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
			stall_phase <= stall_phase + 1;
			if (stall_phase % 200 < 60)
				out_stall <= 1'b0;
			else if (stall_phase % 200 < 120)
				out_stall <= $urandom_range(0, 3) == 0;
			else
				out_stall <= (stall_phase % 7) < 3;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		in_fire <= in_valid && !in_stall;
		if (cycle_count > 400000) begin
			$display("TB_ERROR");
			$finish;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (expected_noise.size() == 0) begin
				report_mismatch("unexpected noise_value", noise_value, 0);
			end else begin
				if (noise_value !== expected_noise[0])
					report_mismatch("noise_value", noise_value, expected_noise[0]);
				void'(expected_noise.pop_front());
			end
		end
	end

	initial begin
		logic [3:0] settings[6];
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_fire = 1'b0;
		x_coord = '0;
		y_coord = '0;
		out_stall = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		mismatch_count = 0;
		cycle_count = 0;
		burst_left = 5;
		gap_left = 0;
		stall_phase = 0;
		driver_hold = 1'b0;
		model_octaves = OCTAVE_RESET;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		queue_point(32'h0, 32'h0);
		queue_point(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_point(32'hFFFF_FFFF, 32'h0);
		queue_point(32'h0, 32'hFFFF_FFFF);
		queue_point(32'h0000_8000, 32'h0000_8000);
		queue_point(32'h0001_0000, 32'h0002_0000);
		queue_point(32'hFFFF_8000, 32'h8000_7FFF);
		queue_point(32'h5555_5555, 32'hAAAA_AAAA);
		queue_point(32'h0000_FFFF, 32'h0001_0001);
		drain();
		settings = '{4'd0, 4'd1, 4'd8, 4'd15, 4'd3, 4'd9};
		foreach (settings[k]) begin
			write_octaves(settings[k]);
			queue_point(32'h0, 32'h0);
			queue_point(32'hFFFF_FFFF, 32'hFFFF_FFFF);
			queue_point(32'h8000_1234, 32'h7FFF_C000);
			drain();
		end
		for (int ph = 0; ph < 6; ph++) begin
			write_octaves($urandom_range(0, 15));
			queue_random(50);
			wait (pending_points.size() < 25);
			driver_hold = 1'b1;
			wait (expected_noise.size() == 0);
			driver_hold = 1'b0;
			queue_random(48);
			drain();
		end
		write_octaves(OCTAVE_RESET);
		queue_random((1 << 5) + 8);
		drain();
		if (mismatch_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
